FILE: sv/epx_pkg.sv
`default_nettype none

package epx_pkg;

   localparam int unsigned FLAG_S = 7;
   localparam int unsigned FLAG_Z = 6;
   localparam int unsigned FLAG_Y = 5;
   localparam int unsigned FLAG_H = 4;
   localparam int unsigned FLAG_X = 3;
   localparam int unsigned FLAG_P = 2;
   localparam int unsigned FLAG_N = 1;
   localparam int unsigned FLAG_C = 0;

   typedef enum logic [3:0] {
      CMD_BLK_LOAD    = 4'd0,
      CMD_BLK_COMPARE = 4'd1,
      CMD_BLK_INPUT   = 4'd2,
      CMD_BLK_OUTPUT  = 4'd3,
      CMD_ADC16       = 4'd4,
      CMD_SBC16       = 4'd5,
      CMD_RLD         = 4'd6,
      CMD_RRD         = 4'd7,
      CMD_IN_FLAGS    = 4'd8,
      CMD_LD_AIR      = 4'd9
   } cmd_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic        decrement;
      logic        repeat_mode;
      logic [7:0]  acc;
      logic [7:0]  flags_in;
      logic [7:0]  data_byte;
      logic [15:0] count_pair;
      logic [15:0] source_pair;
      logic [15:0] dest_pair;
      logic [15:0] operand_pair;
      logic        iff2_bit;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [7:0]  flags_out;
      logic [15:0] count_out;
      logic [15:0] source_out;
      logic [15:0] dest_out;
      logic [7:0]  write_byte;
      logic        repeat_again;
   } rsp_type;

   // sign, zero, and the two undocumented copy bits of an 8-bit result
   function automatic logic [7:0] szyx(input logic [7:0] v);
      logic [7:0] f;
      f         = 8'h00;
      f[FLAG_S] = v[7];
      f[FLAG_Z] = (v == 8'h00);
      f[FLAG_Y] = v[5];
      f[FLAG_X] = v[3];
      return f;
   endfunction

   function automatic logic [7:0] szyxp_keep_c(input logic [7:0] fin, input logic [7:0] v);
      logic [7:0] f;
      f         = szyx(v);
      f[FLAG_P] = ~(^v);
      f[FLAG_C] = fin[FLAG_C];
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: sv/epx_if.sv
`default_nettype none

interface epx_req_if;
   logic             valid;
   logic             ready;
   epx_pkg::req_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface epx_rsp_if;
   logic             valid;
   logic             ready;
   epx_pkg::rsp_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/ed_prefix_execute_unit_core.sv
// Execute unit for one step of the extended-prefix instruction group.
// req_chan carries one step transaction: command, direction, repeat flag,
// accumulator, flags, fetched byte and the BC/HL/DE/operand pairs.
// rsp_chan returns one result transaction per request: new accumulator,
// flags, pairs, the byte to store and the repeat decision.
// Path: a request accepted on req_chan is captured in the input register,
// then its result in the result register, which drives rsp_chan.
// Throughput: one transaction per cycle while rsp_chan.ready stays high; the flag
// and 16-bit add logic sits in a single stage between the two registers.
// Stall: when rsp_chan.ready is low the result register holds, the input
// register fills behind it, and req_chan.ready drops only once both are full.
// Reset clears both valid bits; no request is in flight afterward.
`default_nettype none

module ed_prefix_execute_unit_core (
   input  wire           clock,
   input  wire           reset,
   epx_req_if.sink       req_chan,
   epx_rsp_if.source     rsp_chan
);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   epx_pkg::req_type s1_data_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   epx_pkg::rsp_type rsp_data_ff;
   epx_pkg::rsp_type rsp_data_in;

   logic             s2_ready;
   logic             s1_ready;

   logic [15:0]      step;
   logic [15:0]      bc_dec;
   logic [7:0]       b_dec;
   logic [7:0]       diff8;
   logic [4:0]       diff_lo;
   logic [16:0]      add17;
   logic [16:0]      sub17;
   logic [12:0]      add_lo;
   logic [12:0]      sub_lo;
   logic [15:0]      r16;
   logic [7:0]       a_new;
   logic [7:0]       f_new;

   assign s2_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   assign s1_valid_in  = req_chan.valid || (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s2_ready && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      step    = s1_data_ff.decrement ? 16'hFFFF : 16'h0001;
      bc_dec  = s1_data_ff.count_pair - 16'h0001;
      b_dec   = s1_data_ff.count_pair[15:8] - 8'h01;
      diff8   = s1_data_ff.acc - s1_data_ff.data_byte;
      diff_lo = {1'b0, s1_data_ff.acc[3:0]} - {1'b0, s1_data_ff.data_byte[3:0]};
      add17   = {1'b0, s1_data_ff.source_pair} + {1'b0, s1_data_ff.operand_pair}
                + {16'h0000, s1_data_ff.flags_in[epx_pkg::FLAG_C]};
      sub17   = {1'b0, s1_data_ff.source_pair} - {1'b0, s1_data_ff.operand_pair}
                - {16'h0000, s1_data_ff.flags_in[epx_pkg::FLAG_C]};
      add_lo  = {1'b0, s1_data_ff.source_pair[11:0]} + {1'b0, s1_data_ff.operand_pair[11:0]}
                + {12'h000, s1_data_ff.flags_in[epx_pkg::FLAG_C]};
      sub_lo  = {1'b0, s1_data_ff.source_pair[11:0]} - {1'b0, s1_data_ff.operand_pair[11:0]}
                - {12'h000, s1_data_ff.flags_in[epx_pkg::FLAG_C]};
      r16     = 16'h0000;
      a_new   = s1_data_ff.acc;
      f_new   = 8'h00;

      rsp_data_in.acc_out      = s1_data_ff.acc;
      rsp_data_in.flags_out    = s1_data_ff.flags_in;
      rsp_data_in.count_out    = s1_data_ff.count_pair;
      rsp_data_in.source_out   = s1_data_ff.source_pair;
      rsp_data_in.dest_out     = s1_data_ff.dest_pair;
      rsp_data_in.write_byte   = 8'h00;
      rsp_data_in.repeat_again = 1'b0;

      case (s1_data_ff.cmd)
         epx_pkg::CMD_BLK_LOAD: begin
            rsp_data_in.source_out = s1_data_ff.source_pair + step;
            rsp_data_in.dest_out   = s1_data_ff.dest_pair + step;
            rsp_data_in.count_out  = bc_dec;
            f_new[epx_pkg::FLAG_C] = s1_data_ff.flags_in[epx_pkg::FLAG_C];
            f_new[epx_pkg::FLAG_P] = (bc_dec != 16'h0000);
            rsp_data_in.flags_out    = f_new;
            rsp_data_in.write_byte   = s1_data_ff.data_byte;
            rsp_data_in.repeat_again = s1_data_ff.repeat_mode && (bc_dec != 16'h0000);
         end
         epx_pkg::CMD_BLK_COMPARE: begin
            f_new                  = epx_pkg::szyx(diff8);
            f_new[epx_pkg::FLAG_C] = s1_data_ff.flags_in[epx_pkg::FLAG_C];
            f_new[epx_pkg::FLAG_N] = 1'b1;
            f_new[epx_pkg::FLAG_H] = diff_lo[4];
            f_new[epx_pkg::FLAG_P] = (bc_dec != 16'h0000);
            rsp_data_in.flags_out  = f_new;
            rsp_data_in.source_out = s1_data_ff.source_pair + step;
            rsp_data_in.count_out  = bc_dec;
            rsp_data_in.repeat_again = s1_data_ff.repeat_mode && (bc_dec != 16'h0000)
                                       && !f_new[epx_pkg::FLAG_Z];
         end
         epx_pkg::CMD_BLK_INPUT, epx_pkg::CMD_BLK_OUTPUT: begin
            rsp_data_in.count_out  = {b_dec, s1_data_ff.count_pair[7:0]};
            rsp_data_in.source_out = s1_data_ff.source_pair + step;
            f_new                  = epx_pkg::szyx(b_dec);
            f_new[epx_pkg::FLAG_C] = s1_data_ff.flags_in[epx_pkg::FLAG_C];
            f_new[epx_pkg::FLAG_N] = 1'b1;
            rsp_data_in.flags_out    = f_new;
            rsp_data_in.write_byte   = s1_data_ff.data_byte;
            rsp_data_in.repeat_again = s1_data_ff.repeat_mode && (b_dec != 8'h00);
         end
         epx_pkg::CMD_ADC16: begin
            r16                    = add17[15:0];
            f_new[epx_pkg::FLAG_H] = add_lo[12];
            f_new[epx_pkg::FLAG_P] = ~(s1_data_ff.source_pair[15] ^ s1_data_ff.operand_pair[15])
                                     & (s1_data_ff.source_pair[15] ^ r16[15]);
            f_new[epx_pkg::FLAG_C] = add17[16];
            f_new[epx_pkg::FLAG_S] = r16[15];
            f_new[epx_pkg::FLAG_Z] = (r16 == 16'h0000);
            f_new[epx_pkg::FLAG_Y] = r16[13];
            f_new[epx_pkg::FLAG_X] = r16[11];
            rsp_data_in.flags_out  = f_new;
            rsp_data_in.source_out = r16;
         end
         epx_pkg::CMD_SBC16: begin
            r16                    = sub17[15:0];
            f_new[epx_pkg::FLAG_N] = 1'b1;
            f_new[epx_pkg::FLAG_H] = sub_lo[12];
            f_new[epx_pkg::FLAG_P] = (s1_data_ff.source_pair[15] ^ s1_data_ff.operand_pair[15])
                                     & (s1_data_ff.source_pair[15] ^ r16[15]);
            f_new[epx_pkg::FLAG_C] = sub17[16];
            f_new[epx_pkg::FLAG_S] = r16[15];
            f_new[epx_pkg::FLAG_Z] = (r16 == 16'h0000);
            f_new[epx_pkg::FLAG_Y] = r16[13];
            f_new[epx_pkg::FLAG_X] = r16[11];
            rsp_data_in.flags_out  = f_new;
            rsp_data_in.source_out = r16;
         end
         epx_pkg::CMD_RLD: begin
            a_new                  = {s1_data_ff.acc[7:4], s1_data_ff.data_byte[7:4]};
            rsp_data_in.acc_out    = a_new;
            rsp_data_in.write_byte = {s1_data_ff.data_byte[3:0], s1_data_ff.acc[3:0]};
            rsp_data_in.flags_out  = epx_pkg::szyxp_keep_c(s1_data_ff.flags_in, a_new);
         end
         epx_pkg::CMD_RRD: begin
            a_new                  = {s1_data_ff.acc[7:4], s1_data_ff.data_byte[3:0]};
            rsp_data_in.acc_out    = a_new;
            rsp_data_in.write_byte = {s1_data_ff.acc[3:0], s1_data_ff.data_byte[7:4]};
            rsp_data_in.flags_out  = epx_pkg::szyxp_keep_c(s1_data_ff.flags_in, a_new);
         end
         epx_pkg::CMD_IN_FLAGS: begin
            rsp_data_in.flags_out  = epx_pkg::szyxp_keep_c(s1_data_ff.flags_in,
                                                           s1_data_ff.data_byte);
            rsp_data_in.write_byte = s1_data_ff.data_byte;
         end
         epx_pkg::CMD_LD_AIR: begin
            f_new                  = epx_pkg::szyx(s1_data_ff.data_byte);
            f_new[epx_pkg::FLAG_C] = s1_data_ff.flags_in[epx_pkg::FLAG_C];
            f_new[epx_pkg::FLAG_P] = s1_data_ff.iff2_bit;
            rsp_data_in.flags_out  = f_new;
            rsp_data_in.acc_out    = s1_data_ff.data_byte;
         end
         default: begin
            // unused codes pass everything through
            rsp_data_in.write_byte = 8'h00;
         end
      endcase
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // a full input stage that moves forward always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> rsp_valid_ff)
      else $error("input stage transaction dropped");

   // a stalled input stage must block new requests
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |-> !req_chan.ready)
      else $error("request accepted over a stalled input stage");

   // a stalled input stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stalled input stage changed");

endmodule

`default_nettype wire

FILE: verif/tb_ed_prefix_execute_unit_core.sv
module tb_ed_prefix_execute_unit_core;

   localparam logic [3:0] CMD_UNUSED_FIRST = 4'(epx_pkg::CMD_LD_AIR) + 4'd1;
   localparam logic [3:0] CMD_UNUSED_LAST  = 4'hF;
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX    = 10;

   logic clock = 1'b0;
   logic reset;

   epx_req_if req_chan ();
   epx_rsp_if rsp_chan ();

   ed_prefix_execute_unit_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   epx_pkg::rsp_type expected_results[$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   int      hold_left = 0;
   int      stall_left = 0;
   int      long_hold_reqs = 0;
   int      long_hold_seen = 0;
   bit      sender_gaps_on = 1'b0;
   bit      receiver_stalls_on = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // step predictor
   // ------------------------------------------------------------------
   function automatic logic [7:0] byte_flags(input logic [7:0] v);
      logic [7:0] f;
      f                  = 8'h00;
      f[epx_pkg::FLAG_S] = v[7];
      f[epx_pkg::FLAG_Z] = (v == 8'h00);
      f[epx_pkg::FLAG_Y] = v[5];
      f[epx_pkg::FLAG_X] = v[3];
      return f;
   endfunction

   function automatic epx_pkg::rsp_type predict_step(input epx_pkg::req_type r);
      epx_pkg::rsp_type o;
      logic [15:0] step_amt;
      logic [7:0]  diff8;
      logic [4:0]  low_diff;
      logic [7:0]  new_b;
      logic [16:0] wide;
      logic [12:0] half;
      logic        carry;
      o.acc_out      = r.acc;
      o.flags_out    = r.flags_in;
      o.count_out    = r.count_pair;
      o.source_out   = r.source_pair;
      o.dest_out     = r.dest_pair;
      o.write_byte   = 8'h00;
      o.repeat_again = 1'b0;
      step_amt       = r.decrement ? 16'hFFFF : 16'h0001;
      carry          = r.flags_in[epx_pkg::FLAG_C];
      case (r.cmd)
         epx_pkg::CMD_BLK_LOAD: begin
            o.source_out                 = r.source_pair + step_amt;
            o.dest_out                   = r.dest_pair + step_amt;
            o.count_out                  = r.count_pair - 16'd1;
            o.flags_out                  = 8'h00;
            o.flags_out[epx_pkg::FLAG_C] = carry;
            o.flags_out[epx_pkg::FLAG_P] = (o.count_out != 16'h0000);
            o.write_byte                 = r.data_byte;
            o.repeat_again               = r.repeat_mode && (o.count_out != 16'h0000);
         end
         epx_pkg::CMD_BLK_COMPARE: begin
            diff8                        = r.acc - r.data_byte;
            low_diff                     = {1'b0, r.acc[3:0]} - {1'b0, r.data_byte[3:0]};
            o.source_out                 = r.source_pair + step_amt;
            o.count_out                  = r.count_pair - 16'd1;
            o.flags_out                  = byte_flags(diff8);
            o.flags_out[epx_pkg::FLAG_N] = 1'b1;
            o.flags_out[epx_pkg::FLAG_C] = carry;
            o.flags_out[epx_pkg::FLAG_H] = low_diff[4];
            o.flags_out[epx_pkg::FLAG_P] = (o.count_out != 16'h0000);
            o.repeat_again               = r.repeat_mode && (o.count_out != 16'h0000)
                                           && !o.flags_out[epx_pkg::FLAG_Z];
         end
         epx_pkg::CMD_BLK_INPUT, epx_pkg::CMD_BLK_OUTPUT: begin
            new_b                        = r.count_pair[15:8] - 8'd1;
            o.count_out                  = {new_b, r.count_pair[7:0]};
            o.source_out                 = r.source_pair + step_amt;
            o.flags_out                  = byte_flags(new_b);
            o.flags_out[epx_pkg::FLAG_N] = 1'b1;
            o.flags_out[epx_pkg::FLAG_C] = carry;
            o.write_byte                 = r.data_byte;
            o.repeat_again               = r.repeat_mode && (new_b != 8'h00);
         end
         epx_pkg::CMD_ADC16, epx_pkg::CMD_SBC16: begin
            if (r.cmd == epx_pkg::CMD_ADC16) begin
               wide = {1'b0, r.source_pair} + {1'b0, r.operand_pair} + {16'h0000, carry};
               half = {1'b0, r.source_pair[11:0]} + {1'b0, r.operand_pair[11:0]}
                      + {12'h000, carry};
               o.flags_out                  = 8'h00;
               o.flags_out[epx_pkg::FLAG_P] = (r.source_pair[15] == r.operand_pair[15])
                                              && (wide[15] != r.source_pair[15]);
            end else begin
               wide = {1'b0, r.source_pair} - {1'b0, r.operand_pair} - {16'h0000, carry};
               half = {1'b0, r.source_pair[11:0]} - {1'b0, r.operand_pair[11:0]}
                      - {12'h000, carry};
               o.flags_out                  = 8'h00;
               o.flags_out[epx_pkg::FLAG_N] = 1'b1;
               o.flags_out[epx_pkg::FLAG_P] = (r.source_pair[15] != r.operand_pair[15])
                                              && (wide[15] != r.source_pair[15]);
            end
            o.flags_out[epx_pkg::FLAG_H] = half[12];
            o.flags_out[epx_pkg::FLAG_C] = wide[16];
            o.flags_out[epx_pkg::FLAG_S] = wide[15];
            o.flags_out[epx_pkg::FLAG_Z] = (wide[15:0] == 16'h0000);
            o.flags_out[epx_pkg::FLAG_Y] = wide[13];
            o.flags_out[epx_pkg::FLAG_X] = wide[11];
            o.source_out                 = wide[15:0];
         end
         epx_pkg::CMD_RLD, epx_pkg::CMD_RRD: begin
            if (r.cmd == epx_pkg::CMD_RLD) begin
               o.write_byte = {r.data_byte[3:0], r.acc[3:0]};
               o.acc_out    = {r.acc[7:4], r.data_byte[7:4]};
            end else begin
               o.write_byte = {r.acc[3:0], r.data_byte[7:4]};
               o.acc_out    = {r.acc[7:4], r.data_byte[3:0]};
            end
            o.flags_out                  = byte_flags(o.acc_out);
            o.flags_out[epx_pkg::FLAG_P] = ~^o.acc_out;
            o.flags_out[epx_pkg::FLAG_C] = carry;
         end
         epx_pkg::CMD_IN_FLAGS: begin
            o.flags_out                  = byte_flags(r.data_byte);
            o.flags_out[epx_pkg::FLAG_P] = ~^r.data_byte;
            o.flags_out[epx_pkg::FLAG_C] = carry;
            o.write_byte                 = r.data_byte;
         end
         epx_pkg::CMD_LD_AIR: begin
            o.acc_out                    = r.data_byte;
            o.flags_out                  = byte_flags(r.data_byte);
            o.flags_out[epx_pkg::FLAG_P] = r.iff2_bit;
            o.flags_out[epx_pkg::FLAG_C] = carry;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic epx_pkg::req_type make_step(input logic [3:0] cmd, input logic dec,
                                                  input logic rep, input logic [7:0] acc,
                                                  input logic [7:0] flags,
                                                  input logic [7:0] data,
                                                  input logic [15:0] bc, input logic [15:0] hl,
                                                  input logic [15:0] de, input logic [15:0] rp,
                                                  input logic iff2);
      epx_pkg::req_type r;
      r.cmd          = cmd;
      r.decrement    = dec;
      r.repeat_mode  = rep;
      r.acc          = acc;
      r.flags_in     = flags;
      r.data_byte    = data;
      r.count_pair   = bc;
      r.source_pair  = hl;
      r.dest_pair    = de;
      r.operand_pair = rp;
      r.iff2_bit     = iff2;
      return r;
   endfunction

   function automatic logic [15:0] edge_pair();
      case ($urandom_range(0, 11))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'hFFFF;
         3:       return 16'h8000;
         4:       return 16'h7FFF;
         5:       return {8'h01, 8'($urandom)};
         6:       return {8'h00, 8'($urandom)};
         7:       return 16'h0002;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic epx_pkg::req_type random_step();
      epx_pkg::req_type r;
      if ($urandom_range(0, 19) == 0)
         r.cmd = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      else
         r.cmd = 4'($urandom_range(epx_pkg::CMD_BLK_LOAD, epx_pkg::CMD_LD_AIR));
      r.decrement    = 1'($urandom);
      r.repeat_mode  = 1'($urandom);
      r.acc          = 8'($urandom);
      r.flags_in     = 8'($urandom);
      r.data_byte    = ($urandom_range(0, 7) == 0) ? r.acc : 8'($urandom);
      r.count_pair   = edge_pair();
      r.source_pair  = edge_pair();
      r.dest_pair    = edge_pair();
      r.operand_pair = edge_pair();
      r.iff2_bit     = 1'($urandom);
      return r;
   endfunction

   task automatic send_step(input epx_pkg::req_type r);
      int gap;
      gap = (sender_gaps_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_step(r));
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      // block load: counter hits zero, wraps from zero, pointers wrap
      send_step(make_step(epx_pkg::CMD_BLK_LOAD, 1'b0, 1'b1, 8'h12, 8'hFF, 8'hA5, 16'h0001,
                          16'h1000, 16'h2000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_BLK_LOAD, 1'b1, 1'b1, 8'h00, 8'h00, 8'h5A, 16'h0000,
                          16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
      send_step(make_step(epx_pkg::CMD_BLK_LOAD, 1'b0, 1'b1, 8'hFF, 8'hFE, 8'hFF, 16'h0005,
                          16'hFFFF, 16'hFFFF, 16'h1234, 1'b0));
      // compare: match stops repeat, half borrow, counter runs out
      send_step(make_step(epx_pkg::CMD_BLK_COMPARE, 1'b0, 1'b1, 8'h3C, 8'h01, 8'h3C,
                          16'h0005, 16'h4000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_BLK_COMPARE, 1'b1, 1'b1, 8'h10, 8'h00, 8'h01,
                          16'h0002, 16'h0000, 16'h1111, 16'h0000, 1'b1));
      send_step(make_step(epx_pkg::CMD_BLK_COMPARE, 1'b1, 1'b1, 8'h00, 8'hFF, 8'hFF,
                          16'h0001, 16'h8000, 16'h0000, 16'h0000, 1'b0));
      // block I/O: B reaches zero, B wraps from zero
      send_step(make_step(epx_pkg::CMD_BLK_INPUT, 1'b0, 1'b1, 8'h00, 8'h01, 8'h77,
                          16'h01FF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_BLK_INPUT, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h88,
                          16'h00AB, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_step(make_step(epx_pkg::CMD_BLK_OUTPUT, 1'b0, 1'b0, 8'h55, 8'hFF, 8'h00,
                          16'h80CD, 16'h7FFF, 16'h0000, 16'h0000, 1'b0));
      // 16-bit add/sub: zero with carry, overflow, wrap
      send_step(make_step(epx_pkg::CMD_ADC16, 1'b0, 1'b1, 8'h00, 8'h01, 8'h00, 16'h0000,
                          16'hFFFF, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_ADC16, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                          16'h7FFF, 16'h0000, 16'h0001, 1'b0));
      send_step(make_step(epx_pkg::CMD_ADC16, 1'b1, 1'b0, 8'h00, 8'hFE, 8'h00, 16'hFFFF,
                          16'h0000, 16'hFFFF, 16'h0000, 1'b1));
      send_step(make_step(epx_pkg::CMD_ADC16, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                          16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
      send_step(make_step(epx_pkg::CMD_SBC16, 1'b0, 1'b0, 8'h00, 8'h01, 8'h00, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_SBC16, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000,
                          16'h8000, 16'h0000, 16'h0001, 1'b0));
      send_step(make_step(epx_pkg::CMD_SBC16, 1'b0, 1'b0, 8'h00, 8'hFE, 8'h00, 16'h0000,
                          16'h1234, 16'h0000, 16'h1234, 1'b0));
      // nibble rotates, including an all-zero result, then input-flags and AIR-load steps
      send_step(make_step(epx_pkg::CMD_RLD, 1'b0, 1'b0, 8'hA5, 8'h00, 8'h3C, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_RRD, 1'b0, 1'b0, 8'hA5, 8'hFF, 8'h3C, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_RRD, 1'b0, 1'b0, 8'h00, 8'h01, 8'h00, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_IN_FLAGS, 1'b0, 1'b0, 8'h42, 8'hFF, 8'h00, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_IN_FLAGS, 1'b0, 1'b0, 8'h42, 8'h00, 8'hFF, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_step(make_step(epx_pkg::CMD_LD_AIR, 1'b0, 1'b0, 8'h11, 8'h00, 8'h80, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_step(make_step(epx_pkg::CMD_LD_AIR, 1'b0, 1'b0, 8'h11, 8'hFF, 8'h00, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 1'b0));
      // undefined opcodes pass through
      send_step(make_step(CMD_UNUSED_FIRST, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_step(make_step(CMD_UNUSED_LAST, 1'b0, 1'b1, 8'h5A, 8'hA5, 8'h3C, 16'h0001,
                          16'h8000, 16'h7FFF, 16'h0000, 1'b1));
      wait_for_results();
   endtask

   task automatic test_random_steps();
      int mode;
      for (int chunk = 0; chunk < 22; chunk++) begin
         mode               = (chunk < 4) ? chunk : $urandom_range(0, 3);
         sender_gaps_on     = mode[0];
         receiver_stalls_on = mode[1];
         for (int n = 0; n < 80; n++) send_step(random_step());
      end
   endtask

   task automatic test_receiver_hold();
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      long_hold_reqs++;
      for (int n = 0; n < 60; n++) send_step(random_step());
      wait_for_results();
   endtask

   task automatic test_sender_pause();
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      for (int n = 0; n < 20; n++) send_step(random_step());
      wait_for_results();
      for (int n = 0; n < 20; n++) send_step(random_step());
      wait_for_results();
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (long_hold_seen != long_hold_reqs) begin
         long_hold_seen = long_hold_reqs;
         hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 25) begin
         stall_left = idle_len() - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic log_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) log_error($sformatf("%s expected %h, got %h", name, want, got));
   endtask

   always @(posedge clock) begin
      epx_pkg::rsp_type seen;
      epx_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = rsp_chan.payload;
         if (expected_results.size() == 0) begin
            log_error($sformatf("unexpected transaction %h", seen));
         end else begin
            want = expected_results.pop_front();
            check_field("acc_out", 16'(want.acc_out), 16'(seen.acc_out));
            check_field("flags_out", 16'(want.flags_out), 16'(seen.flags_out));
            check_field("count_out", want.count_out, seen.count_out);
            check_field("source_out", want.source_out, seen.source_out);
            check_field("dest_out", want.dest_out, seen.dest_out);
            check_field("write_byte", 16'(want.write_byte), 16'(seen.write_byte));
            check_field("repeat_again", 16'(want.repeat_again), 16'(seen.repeat_again));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_receiver_hold();
      test_random_steps();
      test_sender_pause();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
